/* rtl/cbl_pkg.sv */
package cbl_pkg;

  localparam int SAMPLE_WIDTH   = 24;
  localparam int COEF_FRAC_BITS = 22;
  localparam int COEF_WIDTH     = COEF_FRAC_BITS + 2;

  // x0 + 2*x1 + x2 needs two bits of headroom over a sample
  localparam int SUM_WIDTH  = SAMPLE_WIDTH + 2;
  // one partial term: s - y1 - y2, and the running accumulator
  localparam int TERM_WIDTH = SAMPLE_WIDTH + 3;
  // accumulator scaled back to sample units before saturation
  localparam int RES_WIDTH  = TERM_WIDTH + 3;
  localparam int CNT_WIDTH  = $clog2(COEF_WIDTH);

  localparam int CFG_IDX_WIDTH = 2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_COEF_B0 = CFG_IDX_WIDTH'(0);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_COEF_A1 = CFG_IDX_WIDTH'(1);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_COEF_A2 = CFG_IDX_WIDTH'(2);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [COEF_WIDTH-1:0]   coef_t;

  // clamp a wide section result to the sample range
  function automatic sample_t sat_sample(input logic signed [RES_WIDTH-1:0] v);
    logic [RES_WIDTH-SAMPLE_WIDTH:0] top;
    sample_t                         r;
    top = v[RES_WIDTH-1:SAMPLE_WIDTH-1];
    if (top == '0 || top == '1) begin
      r = v[SAMPLE_WIDTH-1:0];
    end else if (v[RES_WIDTH-1]) begin
      r = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end else begin
      r = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

/* rtl/cascaded_biquad_lowpass.sv */
// Each sample runs through two sections in turn; each section has a load state, a
// bit-serial multiply-accumulate over the 24 coefficient bits and a round/saturate state.
// A new sample is taken only in idle, which the block reaches once the previous result
// is loaded into the output register; a waiting result stalls that load.
// Reset (rst_n low, synchronous): coefficients, all delay lines and out_valid clear.
module cascaded_biquad_lowpass (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  cbl_pkg::sample_t                      in_sample_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output cbl_pkg::sample_t                      out_sample_out,
  input  logic                                  cfg_we,
  input  logic [cbl_pkg::CFG_IDX_WIDTH-1:0]     cfg_idx,
  input  cbl_pkg::coef_t                        cfg_wdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_MAC  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state_r;
  logic       sec_r;

  cbl_pkg::coef_t coef_b0_r, coef_a1_r, coef_a2_r;
  cbl_pkg::coef_t b0_sr_r, a1_sr_r, a2_sr_r;

  cbl_pkg::sample_t x_r, m_r;
  cbl_pkg::sample_t in_d1_r, in_d2_r, mid_d1_r, mid_d2_r, out_d1_r, out_d2_r;
  cbl_pkg::sample_t out_data_r;
  logic             out_valid_r;

  logic signed [cbl_pkg::SUM_WIDTH-1:0]  s_r, s_nxt;
  logic signed [cbl_pkg::TERM_WIDTH-1:0] acc_r, acc_nxt;
  logic [2:0]                            lsb_r, lsb_nxt;
  logic [cbl_pkg::CNT_WIDTH-1:0]         cnt_r;

  cbl_pkg::sample_t op_x0, op_x1, op_x2, op_y1, op_y2;
  logic signed [cbl_pkg::TERM_WIDTH-1:0] t_b, t_a1, t_a2, term, step;
  logic signed [cbl_pkg::TERM_WIDTH:0]   acc_sum;
  logic                                  last;
  logic [2:0]                            rnd;
  logic signed [cbl_pkg::RES_WIDTH-1:0]  res;
  cbl_pkg::sample_t                      res_sat;
  logic                                  out_free;
  logic                                  result_load;

  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_data_r;
  assign out_free       = !out_valid_r || out_ready;
  assign result_load    = (state_r == ST_DONE) && sec_r && out_free;

  // section operands: the second section reads the old mid line as its input history
  always_comb begin
    if (sec_r) begin
      op_x0 = m_r;
      op_x1 = mid_d1_r;
      op_x2 = mid_d2_r;
      op_y1 = out_d1_r;
      op_y2 = out_d2_r;
    end else begin
      op_x0 = x_r;
      op_x1 = in_d1_r;
      op_x2 = in_d2_r;
      op_y1 = mid_d1_r;
      op_y2 = mid_d2_r;
    end
  end

  assign s_nxt = cbl_pkg::SUM_WIDTH'(op_x0)
               + (cbl_pkg::SUM_WIDTH'(op_x1) <<< 1)
               + cbl_pkg::SUM_WIDTH'(op_x2);

  // one coefficient bit per cycle, LSB first; the top bit carries negative weight
  always_comb begin
    t_b  = b0_sr_r[0] ? cbl_pkg::TERM_WIDTH'(s_r)   : '0;
    t_a1 = a1_sr_r[0] ? cbl_pkg::TERM_WIDTH'(op_y1) : '0;
    t_a2 = a2_sr_r[0] ? cbl_pkg::TERM_WIDTH'(op_y2) : '0;
    term = t_b - t_a1 - t_a2;
    last = (cnt_r == cbl_pkg::CNT_WIDTH'(cbl_pkg::COEF_WIDTH - 1));
    step = last ? -term : term;
    acc_sum = (cbl_pkg::TERM_WIDTH+1)'(acc_r) + (cbl_pkg::TERM_WIDTH+1)'(step);
    acc_nxt = acc_sum[cbl_pkg::TERM_WIDTH:1];
    lsb_nxt = {acc_sum[0], lsb_r[2:1]};
  end

  // product = acc * 2^COEF_WIDTH + shifted-out bits; add half an LSB, drop COEF_FRAC_BITS
  always_comb begin
    rnd     = {1'b0, lsb_r[2:1]} + {2'b00, lsb_r[0]};
    res     = (cbl_pkg::RES_WIDTH'(acc_r) <<< 2) + $signed(cbl_pkg::RES_WIDTH'(rnd));
    res_sat = cbl_pkg::sat_sample(res);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sec_r       <= 1'b0;
      out_valid_r <= 1'b0;
      coef_b0_r   <= '0;
      coef_a1_r   <= '0;
      coef_a2_r   <= '0;
      in_d1_r     <= '0;
      in_d2_r     <= '0;
      mid_d1_r    <= '0;
      mid_d2_r    <= '0;
      out_d1_r    <= '0;
      out_d2_r    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          cbl_pkg::REG_COEF_B0: coef_b0_r <= cfg_wdata;
          cbl_pkg::REG_COEF_A1: coef_a1_r <= cfg_wdata;
          cbl_pkg::REG_COEF_A2: coef_a2_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (result_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            sec_r   <= 1'b0;
            state_r <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          state_r <= ST_MAC;
        end
        ST_MAC: begin
          if (last) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!sec_r) begin
            sec_r   <= 1'b1;
            state_r <= ST_LOAD;
          end else if (out_free) begin
            // advance all delay lines together once both sections are done
            in_d2_r     <= in_d1_r;
            in_d1_r     <= x_r;
            mid_d2_r    <= mid_d1_r;
            mid_d1_r    <= m_r;
            out_d2_r    <= out_d1_r;
            out_d1_r    <= res_sat;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          x_r <= in_sample_in;
        end
      end
      ST_LOAD: begin
        s_r     <= s_nxt;
        b0_sr_r <= coef_b0_r;
        a1_sr_r <= coef_a1_r;
        a2_sr_r <= coef_a2_r;
        acc_r   <= '0;
        lsb_r   <= '0;
        cnt_r   <= '0;
      end
      ST_MAC: begin
        acc_r   <= acc_nxt;
        lsb_r   <= lsb_nxt;
        b0_sr_r <= b0_sr_r >> 1;
        a1_sr_r <= a1_sr_r >> 1;
        a2_sr_r <= a2_sr_r >> 1;
        cnt_r   <= cnt_r + cbl_pkg::CNT_WIDTH'(1);
      end
      ST_DONE: begin
        if (!sec_r) begin
          m_r <= res_sat;
        end else if (out_free) begin
          out_data_r <= res_sat;
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/cbl_checker.sv */
module cbl_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input cbl_pkg::sample_t out_sample_out
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_out))
    else $error("output transaction changed while stalled");

  // one sample in flight: busy right after an input transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a sample is in flight");

  // an idle block stays ready until it gets work
  a_ready_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && !in_valid |=> in_ready)
    else $error("ready dropped without an input transaction");

  // a new result appears exactly as the block returns to idle
  a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result presented while still busy");

endmodule

bind cascaded_biquad_lowpass cbl_checker u_cbl_checker (.*);

/* test/cascaded_biquad_lowpass_test.sv */
`timescale 1ns / 100ps

module cascaded_biquad_lowpass_test;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 800;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_ITEMS    = 115;
  localparam int TAIL_CYCLES    = 60;

  localparam logic [cbl_pkg::CFG_IDX_WIDTH-1:0] REG_UNUSED =
    cbl_pkg::CFG_IDX_WIDTH'(3);

  localparam cbl_pkg::sample_t SAMPLE_MAX =
    cbl_pkg::sample_t'((64'sd1 <<< (cbl_pkg::SAMPLE_WIDTH - 1)) - 1);
  localparam cbl_pkg::sample_t SAMPLE_MIN =
    cbl_pkg::sample_t'(-(64'sd1 <<< (cbl_pkg::SAMPLE_WIDTH - 1)));
  localparam cbl_pkg::coef_t   COEF_MAX   =
    cbl_pkg::coef_t'((64'sd1 <<< (cbl_pkg::COEF_WIDTH - 1)) - 1);
  localparam cbl_pkg::coef_t   COEF_MIN   =
    cbl_pkg::coef_t'(-(64'sd1 <<< (cbl_pkg::COEF_WIDTH - 1)));

  logic                              clk          = 1'b0;
  logic                              rst_n        = 1'b0;
  logic                              in_valid     = 1'b0;
  logic                              in_ready;
  cbl_pkg::sample_t                  in_sample_in = '0;
  logic                              out_valid;
  logic                              out_ready    = 1'b0;
  cbl_pkg::sample_t                  out_sample_out;
  logic                              cfg_we       = 1'b0;
  logic [cbl_pkg::CFG_IDX_WIDTH-1:0] cfg_idx      = '0;
  cbl_pkg::coef_t                    cfg_wdata    = '0;

  cascaded_biquad_lowpass dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata)
  );

  always #4 clk = ~clk;

  // filter model: coefficients and the six delay taps
  cbl_pkg::coef_t   gain_b0, fb_a1, fb_a2;
  cbl_pkg::sample_t x_z1, x_z2, m_z1, m_z2, y_z1, y_z2;

  cbl_pkg::sample_t pending_samples[$];
  cbl_pkg::sample_t predicted_samples[$];

  int  mismatches   = 0;
  int  samples_sent = 0;
  int  results_seen = 0;
  int  n_settings   = 0;
  int  idle_cycles  = 0;
  bit  calm         = 1'b0;
  bit  hold_request = 1'b0;
  int  send_gap     = 0;
  int  ready_gap    = 0;
  int  hold_left    = 0;
  cbl_pkg::sample_t want;

  function automatic cbl_pkg::sample_t lowpass_section(
    cbl_pkg::sample_t x0, cbl_pkg::sample_t x1, cbl_pkg::sample_t x2,
    cbl_pkg::sample_t y1, cbl_pkg::sample_t y2);
    longint acc;
    longint q;
    acc = longint'(gain_b0) * x0 + 2 * longint'(gain_b0) * x1 + longint'(gain_b0) * x2
        - longint'(fb_a1) * y1 - longint'(fb_a2) * y2
        + (longint'(1) <<< (cbl_pkg::COEF_FRAC_BITS - 1));
    q = acc >>> cbl_pkg::COEF_FRAC_BITS;
    if (q > longint'(SAMPLE_MAX)) return SAMPLE_MAX;
    if (q < longint'(SAMPLE_MIN)) return SAMPLE_MIN;
    return cbl_pkg::sample_t'(q);
  endfunction

  // run one sample through both sections and advance the taps
  function automatic cbl_pkg::sample_t filter_sample(cbl_pkg::sample_t x);
    cbl_pkg::sample_t m;
    cbl_pkg::sample_t y;
    m = lowpass_section(x, x_z1, x_z2, m_z1, m_z2);
    y = lowpass_section(m, m_z1, m_z2, y_z1, y_z2);
    x_z2 = x_z1;
    x_z1 = x;
    m_z2 = m_z1;
    m_z1 = m;
    y_z2 = y_z1;
    y_z1 = y;
    return y;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(20, 4);
    return $urandom_range(150, 30);
  endfunction

  function automatic cbl_pkg::sample_t random_sample();
    int r;
    r = $urandom_range(99);
    if (r < 10) return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
    if (r < 55) return cbl_pkg::sample_t'($urandom);
    return cbl_pkg::sample_t'(int'($urandom_range(131071)) - 65536);
  endfunction

  function automatic cbl_pkg::coef_t extreme_coef();
    int r;
    r = $urandom_range(2);
    if (r == 0) return COEF_MAX;
    if (r == 1) return COEF_MIN;
    return '0;
  endfunction

  task automatic write_coef(logic [cbl_pkg::CFG_IDX_WIDTH-1:0] idx, cbl_pkg::coef_t val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      cbl_pkg::REG_COEF_B0: gain_b0 = val;
      cbl_pkg::REG_COEF_A1: fb_a1 = val;
      cbl_pkg::REG_COEF_A2: fb_a2 = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_filter(cbl_pkg::coef_t b0, cbl_pkg::coef_t a1, cbl_pkg::coef_t a2);
    write_coef(cbl_pkg::REG_COEF_B0, b0);
    write_coef(cbl_pkg::REG_COEF_A1, a1);
    write_coef(cbl_pkg::REG_COEF_A2, a2);
    n_settings++;
  endtask

  // hold until every sample is in and every result is out
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || predicted_samples.size() != 0);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_samples.push_back(filter_sample(in_sample_in));
        samples_sent++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          in_sample_in <= pending_samples.pop_front();
          in_valid     <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_gap = 0;
      hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (predicted_samples.size() == 0) begin
          $display("%0t unexpected transaction: expected none actual %0d", $time,
                   out_sample_out);
          mismatches++;
        end else begin
          want = predicted_samples.pop_front();
          if (out_sample_out !== want) begin
            $display("%0t sample_out mismatch: expected %0d actual %0d", $time, want,
                     out_sample_out);
            mismatches++;
          end
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (ready_gap > 0) begin
        ready_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        ready_gap = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no transaction for %0d cycles", $time, idle_cycles);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int kind;
    int sel;
    gain_b0 = '0;
    fb_a1   = '0;
    fb_a2   = '0;
    x_z1 = '0; x_z2 = '0; m_z1 = '0; m_z2 = '0; y_z1 = '0; y_z2 = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset coefficients are zero, so the output stays at zero
    pending_samples = '{SAMPLE_MAX, SAMPLE_MIN, cbl_pkg::sample_t'(0),
                        cbl_pkg::sample_t'(-1)};
    wait_idle();

    // unknown register index must be ignored
    write_coef(REG_UNUSED, cbl_pkg::coef_t'($urandom));
    set_filter(cbl_pkg::coef_t'(409364), cbl_pkg::coef_t'(-3954376),
               cbl_pkg::coef_t'(1398101));
    pending_samples = '{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN,
                        cbl_pkg::sample_t'(0), cbl_pkg::sample_t'(1),
                        cbl_pkg::sample_t'(-1)};
    wait_idle();

    // unstable extremes drive both sections into saturation
    set_filter(COEF_MAX, COEF_MIN, COEF_MAX);
    pending_samples = '{SAMPLE_MAX, SAMPLE_MIN, cbl_pkg::sample_t'(0), SAMPLE_MAX,
                        cbl_pkg::sample_t'(1), SAMPLE_MIN};
    wait_idle();
    set_filter(COEF_MIN, COEF_MAX, COEF_MIN);
    pending_samples = '{SAMPLE_MAX, SAMPLE_MIN, cbl_pkg::sample_t'(0), SAMPLE_MAX,
                        cbl_pkg::sample_t'(1), SAMPLE_MIN};
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      calm = (p % 4 == 3);
      if ($urandom_range(3) == 0) write_coef(REG_UNUSED, cbl_pkg::coef_t'($urandom));
      kind = $urandom_range(2);
      if (kind == 0) begin
        sel = $urandom_range(2);
        if (sel == 0) begin
          set_filter(cbl_pkg::coef_t'(409364), cbl_pkg::coef_t'(-3954376),
                     cbl_pkg::coef_t'(1398101));
        end else if (sel == 1) begin
          set_filter(cbl_pkg::coef_t'(1228502), cbl_pkg::coef_t'(0),
                     cbl_pkg::coef_t'(719675));
        end else begin
          set_filter(cbl_pkg::coef_t'(35413), cbl_pkg::coef_t'(-7230063),
                     cbl_pkg::coef_t'(3179421));
        end
      end else if (kind == 1) begin
        set_filter(cbl_pkg::coef_t'($urandom), cbl_pkg::coef_t'($urandom),
                   cbl_pkg::coef_t'($urandom));
      end else begin
        set_filter(extreme_coef(), extreme_coef(), extreme_coef());
      end
      // fill the block while the receiver holds off
      if (p == 3) begin
        @(negedge clk);
        hold_request = 1'b1;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) pending_samples.push_back(random_sample());
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (predicted_samples.size() != 0) begin
      $display("%0t %0d results never arrived", $time, predicted_samples.size());
      mismatches++;
    end
    $display("sent %0d samples, checked %0d results over %0d coefficient settings",
             samples_sent, results_seen, n_settings);
    $display("settings spanned stable low-pass, random and saturating extremes");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
